// ===== design/gpdc_pkg.sv =====
package gpdc_pkg;

  // Widths of the day count and of the signed day offset that feeds it.
  localparam int unsigned CntW = 17;
  localparam int unsigned OffW = 12;
  localparam int unsigned IdxW = 7;
  localparam int unsigned AddW = 9;

  localparam int unsigned GregBaseYear  = 1981;
  localparam int unsigned EpochOffset   = 79;
  localparam int unsigned SolarBaseYear = 1360;
  localparam int unsigned DaysPerYear   = 365;
  localparam int unsigned SolarCentHigh = 1300;
  localparam int unsigned SolarCentLow  = 1400;
  localparam int unsigned YearWalkMax   = 100;
  localparam int unsigned MonthCount    = 12;

  // Year offsets folded out of the century arithmetic.
  localparam int unsigned GregYearBias  = 2000 - 1 - GregBaseYear;
  localparam int unsigned SolarHighBias = SolarBaseYear + 1 - SolarCentHigh;
  localparam int unsigned SolarLowBias  = SolarCentLow - 1 - SolarBaseYear;
  localparam int unsigned SolarSplitYy  = 90;
  localparam int unsigned SolarShortYrs = 14;
  localparam int unsigned SolarShortSub = 11;
  localparam int unsigned SolarShortAdd = 3;
  localparam int unsigned GregLeapSplit = 13;
  localparam int unsigned SolarLeapYr   = 73;
  localparam int unsigned PersianYrBase = 60;
  localparam int unsigned GregYrBase    = 81;

  localparam logic ActToPersian = 1'b0;
  localparam logic ActToGreg    = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
  } gpdc_in_t;

  typedef struct packed {
    logic [7:0] out_year_bcd;
    logic [4:0] out_month_bcd;
    logic [5:0] out_day_bcd;
    logic       valid_res;
  } gpdc_out_t;

  typedef struct packed {
    logic            mo_ok;
    logic            dir;
    logic [7:0]      years;
    logic [OffW-1:0] off;
  } gpdc_prep_t;

  typedef struct packed {
    logic in_ready;
    logic load_count;
    logic acc_clear;
    logic acc_step;
    logic year_phase;
    logic cap_year;
    logic cap_month;
    logic load_out;
  } gpdc_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } gpdc_state_e;

  // Nibbles are weighted as they stand, with no decimal check.
  function automatic logic [7:0] from_bcd(logic [7:0] v);
    return {4'd0, v[7:4]} * 8'd10 + {4'd0, v[3:0]};
  endfunction

  // Two BCD digits of a value below 100, tens by a reciprocal multiply.
  function automatic logic [7:0] to_bcd(logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {8'd0, v} * 15'd205;
    tens = prod[14:11];
    ones = v - ({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  // Day offset of the months that precede the given one, beyond 30 a month.
  function automatic logic [OffW-1:0] greg_adj(logic [3:0] idx);
    logic [OffW-1:0] r;
    unique case (idx) inside
      4'd1:                r = OffW'(1);
      4'd2:                r = {OffW{1'b1}};
      4'd5, 4'd6:          r = OffW'(1);
      4'd7:                r = OffW'(2);
      4'd8, 4'd9:          r = OffW'(3);
      4'd10, 4'd11:        r = OffW'(4);
      4'd12:               r = OffW'(5);
      default:             r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [OffW-1:0] solar_adj(logic [3:0] idx);
    logic [OffW-1:0] r;
    unique case (idx) inside
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5: r = OffW'(idx);
      4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: r = OffW'(6);
      4'd12:               r = OffW'(5);
      default:             r = '0;
    endcase
    return r;
  endfunction

  // Month lengths, indexed from zero for the first month.
  function automatic logic [4:0] greg_len(logic [3:0] m);
    logic [4:0] r;
    unique case (m) inside
      4'd1:                     r = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  r = 5'd30;
      default:                  r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] solar_len(logic [3:0] m);
    logic [4:0] r;
    unique case (m) inside
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: r = 5'd31;
      4'd11:                              r = 5'd29;
      default:                            r = 5'd30;
    endcase
    return r;
  endfunction

endpackage

// ===== design/gpdc_prep.sv =====
module gpdc_prep
  import gpdc_pkg::*;
(
  input  gpdc_in_t   in_i,
  output gpdc_prep_t prep_o
);

  logic [7:0]      yy;
  logic [4:0]      mo;
  logic [5:0]      dd;
  logic [3:0]      mm1;
  logic [8:0]      thirty;
  logic [7:0]      g_years;
  logic [7:0]      s_years;
  logic [7:0]      g_leap;
  logic [7:0]      s_leap;
  logic            g_fix;
  logic [OffW-1:0] g_off;
  logic [OffW-1:0] s_off;

  always_comb begin
    yy     = from_bcd(in_i.year_bcd);
    mo     = 5'(from_bcd({3'd0, in_i.month_bcd}));
    dd     = 6'(from_bcd({2'd0, in_i.day_bcd}));
    mm1    = 4'(mo - 5'd1);
    thirty = {5'd0, mm1} * 9'd30;

    g_years = yy + 8'(GregYearBias);
    g_leap  = (g_years + 8'd1) >> 2;
    g_fix   = (mo > 5'd2) && (g_years[1:0] == 2'd2);
    g_off   = OffW'(g_leap) + OffW'(thirty) + greg_adj(mm1) + OffW'(dd)
              + OffW'(g_fix) - OffW'(EpochOffset);

    // Solar years of the upper century wrap to the 1300s.
    if (yy > 8'(SolarSplitYy)) begin
      s_years = yy - 8'(SolarHighBias);
    end else begin
      s_years = yy + 8'(SolarLowBias);
    end
    if (s_years < 8'(SolarShortYrs)) begin
      s_leap = (s_years + 8'd2) >> 2;
    end else begin
      s_leap = 8'(SolarShortAdd) + ((s_years - 8'(SolarShortSub)) >> 2);
    end
    s_off = OffW'(s_leap) + OffW'(thirty) + solar_adj(mm1) + OffW'(dd)
            + OffW'(EpochOffset);

    prep_o.mo_ok = (mo >= 5'd1) && (mo <= 5'(MonthCount));
    prep_o.dir   = in_i.action;
    prep_o.years = (in_i.action == ActToGreg) ? s_years : g_years;
    prep_o.off   = (in_i.action == ActToGreg) ? s_off : g_off;
  end

endmodule

// ===== design/gpdc_acc.sv =====
module gpdc_acc
  import gpdc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gpdc_ctrl_t      ctrl_i,
  input  logic [AddW-1:0] addend_i,
  input  logic [CntW-1:0] target_i,
  output logic            hit_o,
  output logic [CntW-1:0] diff_o
);

  logic [CntW-1:0] acc_q, acc_d;
  logic [CntW-1:0] sum;

  // The running total before a step is also the previous boundary, so the
  // remainder is taken against it directly.
  always_comb begin
    sum    = acc_q + CntW'(addend_i);
    hit_o  = (sum >= target_i);
    diff_o = target_i - acc_q;
    acc_d  = acc_q;
    if (ctrl_i.acc_clear) begin
      acc_d = '0;
    end else if (ctrl_i.acc_step) begin
      acc_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== design/gpdc_ctrl.sv =====
module gpdc_ctrl
  import gpdc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            mo_ok_i,
  input  logic            hit_i,
  input  logic            out_free_i,
  output gpdc_ctrl_t      ctrl_o,
  output logic [IdxW-1:0] idx_o
);

  gpdc_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            last_year;
  logic            last_month;

  assign last_year  = (idx_q == IdxW'(YearWalkMax - 1));
  assign last_month = (idx_q == IdxW'(MonthCount - 1));
  assign idx_o      = idx_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = mo_ok_i ? ST_COUNT : ST_FINISH;
        end
      end
      ST_COUNT: state_d = ST_YEAR;
      ST_YEAR: begin
        if (hit_i) begin
          state_d = ST_MONTH;
        end else if (last_year) begin
          state_d = ST_FINISH;
        end
      end
      ST_MONTH: begin
        if (hit_i || last_month) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    idx_d  = idx_q;
    unique case (state_q)
      ST_IDLE: ctrl_o.in_ready = 1'b1;
      ST_COUNT: begin
        ctrl_o.load_count = 1'b1;
        ctrl_o.acc_clear  = 1'b1;
        idx_d             = '0;
      end
      ST_YEAR: begin
        ctrl_o.year_phase = 1'b1;
        ctrl_o.acc_step   = 1'b1;
        if (hit_i) begin
          ctrl_o.cap_year  = 1'b1;
          ctrl_o.acc_clear = 1'b1;
          idx_d            = '0;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_MONTH: begin
        ctrl_o.acc_step  = 1'b1;
        ctrl_o.cap_month = hit_i;
        idx_d            = idx_q + IdxW'(1);
      end
      ST_FINISH: ctrl_o.load_out = out_free_i;
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== design/gregorian_persian_date_converter.sv =====
// Channel | Direction | Handshake                  | Word
// in      | input     | in_valid_i / in_ready_o    | in_data_i  (gpdc_in_t)
// out     | output    | out_valid_o / out_ready_i  | out_data_o (gpdc_out_t)
//
// After acceptance a word has its day count loaded, then walks the years (1 to
// 100 of them) and the months (1 to 12, none if the year walk runs out) before
// its result is loaded; a month outside 1 to 12 goes straight to the result. The
// shared accumulate-and-compare unit takes one year or one month per cycle.
// Reset clears the sequencer and the output valid. A waiting result does not
// block the next input; only the final load waits for the output register.
module gregorian_persian_date_converter
  import gpdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gpdc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gpdc_out_t out_data_o
);

  gpdc_prep_t      prep;
  gpdc_ctrl_t      ctrl;
  logic [IdxW-1:0] idx;
  logic            hit;
  logic [CntW-1:0] diff;
  logic [AddW-1:0] addend;
  logic [CntW-1:0] target;
  logic            out_free;
  logic            in_fire;

  logic            dir_q;
  logic [7:0]      years_q;
  logic [OffW-1:0] off_q;
  logic [CntW-1:0] count_q;
  logic [7:0]      yr_q;
  logic [AddW-1:0] rem_q;
  logic [3:0]      mon_q;
  logic [5:0]      day_q;
  logic            res_valid_q;
  gpdc_out_t       out_q;
  logic            out_valid_q;

  logic            y_leap;
  logic            m_leap;
  logic [7:0]      yp1;
  logic [6:0]      y_mod;
  gpdc_out_t       res;

  gpdc_prep u_prep (
    .in_i   (in_data_i),
    .prep_o (prep)
  );

  gpdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mo_ok_i    (prep.mo_ok),
    .hit_i      (hit),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .idx_o      (idx)
  );

  gpdc_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .addend_i (addend),
    .target_i (target),
    .hit_o    (hit),
    .diff_o   (diff)
  );

  assign in_ready_o  = ctrl.in_ready;
  assign in_fire     = in_valid_i && ctrl.in_ready;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Leap days of the two walks follow each direction's own rules.
  always_comb begin
    if (dir_q == ActToGreg) begin
      y_leap = (idx[1:0] == 2'd2);
      m_leap = (idx[3:0] == 4'd1) && (yr_q[1:0] == 2'd3);
    end else begin
      y_leap = ((idx[1:0] == 2'd1) && (idx < IdxW'(GregLeapSplit)))
            || ((idx[1:0] == 2'd2) && (idx > IdxW'(GregLeapSplit)));
      m_leap = (idx[3:0] == 4'(MonthCount - 1))
            && (((yr_q[1:0] == 2'd1) && (yr_q < 8'(SolarLeapYr)))
             || ((yr_q[1:0] == 2'd2) && (yr_q > 8'(SolarLeapYr))));
    end

    if (ctrl.year_phase) begin
      addend = AddW'(DaysPerYear) + AddW'(y_leap);
      target = count_q;
    end else begin
      addend = (dir_q == ActToGreg) ? AddW'(greg_len(idx[3:0])) : AddW'(solar_len(idx[3:0]));
      addend = addend + AddW'(m_leap);
      target = CntW'(rem_q);
    end
  end

  always_comb begin
    yp1   = yr_q + 8'd1;
    y_mod = (yp1 >= 8'd100) ? 7'(yp1 - 8'd100) : yp1[6:0];
    if (res_valid_q) begin
      res.out_year_bcd  = to_bcd(y_mod);
      res.out_month_bcd = 5'(to_bcd({3'd0, mon_q}));
      res.out_day_bcd   = 6'(to_bcd({1'b0, day_q}));
      res.valid_res     = 1'b1;
    end else begin
      res = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dir_q   <= prep.dir;
      years_q <= prep.years;
      off_q   <= prep.off;
    end
    if (ctrl.load_count) begin
      count_q <= ({9'd0, years_q} * CntW'(DaysPerYear)) + {{(CntW - OffW){off_q[OffW-1]}}, off_q};
    end
    if (ctrl.cap_year) begin
      yr_q  <= (dir_q == ActToGreg) ? 8'(GregYrBase) + 8'(idx) : 8'(PersianYrBase) + 8'(idx);
      rem_q <= diff[AddW-1:0];
    end
    if (ctrl.cap_month) begin
      mon_q <= idx[3:0] + 4'd1;
      day_q <= diff[5:0];
    end
    if (ctrl.load_out) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        res_valid_q <= 1'b0;
      end else if (ctrl.cap_month) begin
        res_valid_q <= 1'b1;
      end
      if (ctrl.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== design/gpdc_checker.sv =====
module gpdc_checker
  import gpdc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input gpdc_out_t out_data_o
);

  // An accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again right after a word was taken");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |->
      (out_data_o.out_year_bcd == 8'd0) && (out_data_o.out_month_bcd == 5'd0)
      && (out_data_o.out_day_bcd == 6'd0))
    else $error("invalid result carries nonzero fields");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_res |->
      (out_data_o.out_month_bcd != 5'd0) && (out_data_o.out_month_bcd <= 5'h12))
    else $error("valid result has a month outside 1 to 12");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before acceptance");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

endmodule

bind gregorian_persian_date_converter gpdc_checker u_gpdc_checker (.*);
